// ===== src/scbc_pkg.sv =====
// Shared types, codes and size-class constants for the size-class block cache.
package scbc_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SIZE_W   = 40;
  localparam int unsigned BUDGET_W = 24;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd8388608;
  // Requests at or below this size bypass the classes
  localparam logic [SIZE_W-1:0]   SMALL_LIMIT  = 40'd32768;

  // Class i has size (5 + i mod 4) << (13 + i / 4)
  localparam int unsigned CLS_MANT_BASE  = 5;
  localparam int unsigned CLS_SHIFT_BASE = 13;

  typedef enum logic [2:0] {
    ACT_CACHED  = 3'd0,
    ACT_MALLOC  = 3'd1,
    ACT_REALLOC = 3'd2,
    ACT_KEEP    = 3'd3,
    ACT_NONE    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    FATE_NONE  = 2'd0,
    FATE_KEPT  = 2'd1,
    FATE_FREED = 2'd2
  } fate_e;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    logic [SIZE_W-1:0] block_usable;
    logic [SIZE_W-1:0] old_size;
    logic [SIZE_W-1:0] new_size;
  } req_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] backing_size;
    logic [SIZE_W-1:0] copy_bytes;
    logic [1:0]        old_fate;
  } rsp_t;

  // Byte size of one size class
  function automatic logic [SIZE_W-1:0] class_size(input int unsigned idx);
    logic [SIZE_W-1:0] mant;
    mant = SIZE_W'(CLS_MANT_BASE + (idx & 32'd3));
    return mant << (CLS_SHIFT_BASE + (idx >> 2));
  endfunction

endpackage

// ===== src/size_class_block_cache.sv =====
// Top level of the size-class block cache: call sequencer, byte total and stores.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o  in_req_i  (scbc_pkg::req_t)
//   out       output     out_valid_o/ out_stall_i out_rsp_o (scbc_pkg::rsp_t)
//   cfg       input      cfg_we_i                 cfg_wdata_i (byte budget)
//
// Each call passes through a count read, a stack read, and a write-back of the
// stack entry, counts and byte total. The count and stack memories each have a
// registered read. Reset clears the counts by valid bits at once; no clearing
// pass. A result waits in the output register while stalled; the next call is
// accepted meanwhile and holds in its last cycle.
module size_class_block_cache #(
  parameter int SIZE_CLASSES     = 24,
  parameter int BLOCKS_PER_CLASS = 64,
  parameter int ADDR_BITS        = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  scbc_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output scbc_pkg::rsp_t                out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [scbc_pkg::BUDGET_W-1:0] cfg_wdata_i
);
  import scbc_pkg::*;

  localparam int CW     = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int SW     = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
  localparam int KW     = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int IW     = CW + SW;
  localparam logic [SIZE_W-1:0] MAX_CLS = class_size(SIZE_CLASSES - 1);
  localparam int BLK_W  = $clog2(int'(MAX_CLS) * 2 + 1);
  localparam int SUM_W  = ((BUDGET_W > BLK_W) ? BUDGET_W : BLK_W) + 1;
  localparam logic [KW-1:0] KFULL = KW'(BLOCKS_PER_CLASS);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CNT  = 2'd1;
  localparam logic [1:0] ST_BLK  = 2'd2;

  // Call kinds
  localparam logic [1:0] OP_REL  = 2'd0;
  localparam logic [1:0] OP_FWD  = 2'd1;
  localparam logic [1:0] OP_KEEP = 2'd2;
  localparam logic [1:0] OP_MOVE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [BUDGET_W-1:0]  budget_q;
  logic [BUDGET_W-1:0]  total_q, total_d;
  logic                 out_valid_q;
  rsp_t                 rsp_q, rsp_d;

  // Per-call registers
  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 addr_nz_q;
  logic [BLK_W-1:0]     usable_q;
  logic [SIZE_W-1:0]    nsize_q;
  logic [SIZE_W-1:0]    copy_q;
  logic [CW-1:0]        fit_q, floor_q;
  logic                 floor_ok_q;
  logic                 take_q;
  logic [KW-1:0]        ko_q;
  logic [SUM_W-1:0]     sum_q;

  // Class map and memory wiring
  logic                 fit_ok, floor_ok;
  logic [CW-1:0]        fit, floor_c;
  logic [KW-1:0]        kf, ko;
  logic                 cnt_we;
  logic [CW-1:0]        cnt_waddr;
  logic [KW-1:0]        cnt_wdata;
  logic                 stk_re, stk_we;
  logic [IW-1:0]        stk_raddr, stk_waddr;
  logic [ADDR_BITS-1:0] stk_addr;
  logic [BLK_W-1:0]     stk_size;

  logic                 accept;
  logic                 out_free;
  logic [63:0]          in_addr_w;
  logic [ADDR_BITS-1:0] in_addr;
  logic [1:0]           in_op;
  logic [KW-1:0]        kf_dec;
  logic                 take_go;
  logic [BLK_W-1:0]     taken;
  logic                 budget_ok;
  logic                 offer_go;
  logic                 offer_try;
  logic [63:0]          res_addr_w;

  scbc_class_map #(
    .SIZE_CLASSES(SIZE_CLASSES),
    .CW          (CW)
  ) u_class_map (
    .new_size_i(in_req_i.new_size),
    .usable_i  (in_req_i.block_usable),
    .fit_ok_o  (fit_ok),
    .fit_o     (fit),
    .floor_ok_o(floor_ok),
    .floor_o   (floor_c)
  );

  scbc_count_mem #(
    .SIZE_CLASSES(SIZE_CLASSES),
    .CW          (CW),
    .KW          (KW)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr0_i(fit),
    .raddr1_i(floor_c),
    .rdata0_o(kf),
    .rdata1_o(ko),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata)
  );

  scbc_stack_mem #(
    .IW          (IW),
    .ADDR_BITS   (ADDR_BITS),
    .BLK_W       (BLK_W)
  ) u_stack_mem (
    .clk_i    (clk_i),
    .re_i     (stk_re),
    .raddr_i  (stk_raddr),
    .rd_addr_o(stk_addr),
    .rd_size_o(stk_size),
    .we_i     (stk_we),
    .waddr_i  (stk_waddr),
    .wr_addr_i(addr_q),
    .wr_size_i(usable_q)
  );

  // Accept side
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_addr_w  = 64'(in_req_i.block_addr);
  assign in_addr    = in_addr_w[ADDR_BITS-1:0];

  // Classify the call
  always_comb begin
    if (in_req_i.new_size == '0) begin
      in_op = OP_REL;
    end else if (!fit_ok) begin
      in_op = OP_FWD;
    end else if ((in_addr != '0) && floor_ok && (floor_c == fit)) begin
      in_op = OP_KEEP;
    end else begin
      in_op = OP_MOVE;
    end
  end

  // Pop decision in the count cycle
  assign kf_dec    = kf - KW'(1);
  assign take_go   = (op_q == OP_MOVE) && (kf != '0);
  assign stk_re    = (state_q == ST_CNT) && take_go;
  assign stk_raddr = {fit_q, kf_dec[SW-1:0]};

  // Push decision in the write-back cycle
  assign taken     = take_q ? stk_size : '0;
  assign budget_ok = ({1'b0, sum_q} <= ((SUM_W + 1)'(budget_q) + (SUM_W + 1)'(taken)));
  assign offer_try = ((op_q == OP_REL) || (op_q == OP_MOVE)) && addr_nz_q;
  assign offer_go  = offer_try && floor_ok_q && (ko_q < KFULL) && budget_ok;
  assign stk_we    = (state_q == ST_BLK) && out_free && offer_go;
  assign stk_waddr = {floor_q, ko_q[SW-1:0]};

  // Count write port: pop in the count cycle, push in the write-back cycle
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = fit_q;
    cnt_wdata = kf_dec;
    if (state_q == ST_CNT) begin
      cnt_we = take_go;
    end else if (state_q == ST_BLK) begin
      cnt_we    = out_free && offer_go;
      cnt_waddr = floor_q;
      cnt_wdata = ko_q + KW'(1);
    end
  end

  // Build the result
  assign res_addr_w = 64'(take_q ? stk_addr : addr_q);
  always_comb begin
    rsp_d              = '0;
    rsp_d.action       = ACT_NONE;
    rsp_d.old_fate     = FATE_NONE;
    unique case (op_q)
      OP_REL: begin
        rsp_d.action = ACT_NONE;
      end
      OP_FWD: begin
        rsp_d.action       = addr_nz_q ? ACT_REALLOC : ACT_MALLOC;
        rsp_d.backing_size = nsize_q;
      end
      OP_KEEP: begin
        rsp_d.action      = ACT_KEEP;
        rsp_d.result_addr = res_addr_w[ADDR_W-1:0];
      end
      OP_MOVE: begin
        if (take_q) begin
          rsp_d.action      = ACT_CACHED;
          rsp_d.result_addr = res_addr_w[ADDR_W-1:0];
        end else begin
          rsp_d.action       = ACT_MALLOC;
          rsp_d.backing_size = class_size(int'(fit_q));
        end
        rsp_d.copy_bytes = addr_nz_q ? copy_q : '0;
      end
      default: begin
        rsp_d.action = ACT_NONE;
      end
    endcase
    if (offer_try) begin
      rsp_d.old_fate = offer_go ? FATE_KEPT : FATE_FREED;
    end
  end

  // Next byte total: drop the taken block, then add the kept one
  always_comb begin
    total_d = total_q;
    if ((state_q == ST_BLK) && out_free) begin
      total_d = offer_go ? BUDGET_W'(sum_q - SUM_W'(taken))
                         : BUDGET_W'(total_q - BUDGET_W'(taken));
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CNT;
      ST_CNT:  state_d = ST_BLK;
      ST_BLK:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      budget_q    <= BUDGET_RESET;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        budget_q <= cfg_wdata_i;
      end
      if ((state_q == ST_BLK) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold call fields and per-stage decisions
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= in_op;
      addr_q     <= in_addr;
      addr_nz_q  <= (in_addr != '0);
      usable_q   <= in_req_i.block_usable[BLK_W-1:0];
      nsize_q    <= in_req_i.new_size;
      copy_q     <= (in_req_i.old_size < in_req_i.new_size) ? in_req_i.old_size
                                                             : in_req_i.new_size;
      fit_q      <= fit;
      floor_q    <= floor_c;
      floor_ok_q <= floor_ok;
    end
    if (state_q == ST_CNT) begin
      take_q <= take_go;
      ko_q   <= ko;
      sum_q  <= SUM_W'(total_q) + SUM_W'(usable_q);
    end
    if ((state_q == ST_BLK) && out_free) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== src/scbc_class_map.sv =====
// Maps a requested size to its serving class and a usable size to its holding class.
module scbc_class_map #(
  parameter int SIZE_CLASSES = 24,
  parameter int CW           = 5
) (
  input  logic [scbc_pkg::SIZE_W-1:0] new_size_i,
  input  logic [scbc_pkg::SIZE_W-1:0] usable_i,
  output logic                        fit_ok_o,
  output logic [CW-1:0]               fit_o,
  output logic                        floor_ok_o,
  output logic [CW-1:0]               floor_o
);
  import scbc_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_CLS = class_size(SIZE_CLASSES - 1);
  localparam logic [SIZE_W-1:0] MIN_CLS = class_size(0);

  // Smallest class that holds the request
  always_comb begin
    fit_ok_o = (new_size_i > SMALL_LIMIT) && (new_size_i <= MAX_CLS);
    fit_o    = '0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (class_size(i) >= new_size_i) begin
        fit_o = CW'(i);
      end
    end
  end

  // Largest class the block can stand for
  always_comb begin
    floor_ok_o = (usable_i >= MIN_CLS) && (usable_i <= (MAX_CLS << 1));
    floor_o    = '0;
    for (int i = 0; i < SIZE_CLASSES; i++) begin
      if (class_size(i) <= usable_i) begin
        floor_o = CW'(i);
      end
    end
  end

endmodule

// ===== src/scbc_count_mem.sv =====
// Per-class fill counts: small memory with two read ports, one write port, valid bits.
module scbc_count_mem #(
  parameter int SIZE_CLASSES = 24,
  parameter int CW           = 5,
  parameter int KW           = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [CW-1:0] raddr0_i,
  input  logic [CW-1:0] raddr1_i,
  output logic [KW-1:0] rdata0_o,
  output logic [KW-1:0] rdata1_o,
  input  logic          we_i,
  input  logic [CW-1:0] waddr_i,
  input  logic [KW-1:0] wdata_i
);

  logic [KW-1:0]           mem_q [SIZE_CLASSES];
  logic [SIZE_CLASSES-1:0] valid_q;
  logic [KW-1:0]           rd0_q, rd1_q;
  logic                    rv0_q, rv1_q;

  // Write and read the count array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd0_q <= mem_q[raddr0_i];
      rd1_q <= mem_q[raddr1_i];
    end
  end

  // Track written entries; an unwritten count reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv0_q   <= 1'b0;
      rv1_q   <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rv0_q <= valid_q[raddr0_i];
        rv1_q <= valid_q[raddr1_i];
      end
    end
  end

  assign rdata0_o = rv0_q ? rd0_q : '0;
  assign rdata1_o = rv1_q ? rd1_q : '0;

endmodule

// ===== src/scbc_stack_mem.sv =====
// Per-class block stacks: address and usable size, one read and one write port.
module scbc_stack_mem #(
  parameter int IW           = 11,
  parameter int ADDR_BITS    = 48,
  parameter int BLK_W        = 23
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [IW-1:0]        raddr_i,
  output logic [ADDR_BITS-1:0] rd_addr_o,
  output logic [BLK_W-1:0]     rd_size_o,
  input  logic                 we_i,
  input  logic [IW-1:0]        waddr_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  logic [BLK_W-1:0]     wr_size_i
);

  localparam int DEPTH = 1 << IW;

  logic [ADDR_BITS+BLK_W-1:0] mem_q [DEPTH];
  logic [ADDR_BITS+BLK_W-1:0] rd_q;

  // Write on push, read on pop; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wr_addr_i, wr_size_i};
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rd_addr_o = rd_q[ADDR_BITS+BLK_W-1:BLK_W];
  assign rd_size_o = rd_q[BLK_W-1:0];

endmodule

// ===== tb/tb_size_class_block_cache.sv =====
// Self-checking testbench for the size-class block cache top level.
module tb_size_class_block_cache;
  import scbc_pkg::*;

  localparam int NCLS  = 24;
  localparam int DEPTH = 64;
  localparam int unsigned BUDGET_MAX = 8388608;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  req_t   in_req_i;
  logic   out_valid_o;
  logic   out_stall_i;
  rsp_t   out_rsp_o;
  logic   cfg_we_i;
  logic [BUDGET_W-1:0] cfg_wdata_i;

  // Shadow of the cache: per-class stacks, fill counts, byte total and budget
  logic [ADDR_W-1:0] stk_addr [NCLS][DEPTH];
  logic [SIZE_W-1:0] stk_size [NCLS][DEPTH];
  int                fill_cnt [NCLS];
  longint unsigned   cached_total;
  longint unsigned   budget_shadow;

  rsp_t pending_rsp_q [$];
  int   err_count;
  int   req_count;
  int   rsp_count;
  int   hit_count;
  int   keep_count;
  int   stash_count;

  // Receiver pacing
  bit   idle_on;
  bit   hold_rx;
  bit   got_rsp;
  int   stall_left;

  size_class_block_cache u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bytes of class i: (5 + i mod 4) << (13 + i / 4)
  function automatic longint unsigned cls_bytes(int i);
    return longint'(5 + i % 4) << (13 + i / 4);
  endfunction

  // Largest class a block of this usable size stands for, -1 if not cacheable
  function automatic int floor_class(logic [SIZE_W-1:0] u);
    int c;
    if (u < cls_bytes(0) || u > 2 * cls_bytes(NCLS-1)) return -1;
    c = NCLS - 1;
    while (c > 0 && cls_bytes(c) > u) c--;
    return c;
  endfunction

  // Push an old block onto its class stack if count and budget allow
  function automatic logic [1:0] offer_old(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] u);
    int c;
    if (a == 0) return FATE_NONE;
    c = floor_class(u);
    if (c >= 0 && fill_cnt[c] < DEPTH && cached_total + u <= budget_shadow) begin
      stk_addr[c][fill_cnt[c]] = a;
      stk_size[c][fill_cnt[c]] = u;
      fill_cnt[c]++;
      cached_total += u;
      return FATE_KEPT;
    end
    return FATE_FREED;
  endfunction

  // Work out the response to one allocator call and advance the shadow state
  function automatic rsp_t predict_call(req_t r);
    rsp_t p;
    int   fit;
    p = '0;
    p.action = ACT_NONE;
    if (r.new_size == 0) begin
      p.old_fate = offer_old(r.block_addr, r.block_usable);
    end else begin
      fit = -1;
      if (r.new_size > SMALL_LIMIT && r.new_size <= cls_bytes(NCLS-1)) begin
        for (int i = NCLS - 1; i >= 0; i--) begin
          if (cls_bytes(i) >= r.new_size) fit = i;
        end
      end
      if (fit < 0) begin
        p.action       = (r.block_addr == 0) ? ACT_MALLOC : ACT_REALLOC;
        p.backing_size = r.new_size;
      end else if (r.block_addr != 0 && floor_class(r.block_usable) == fit) begin
        p.action      = ACT_KEEP;
        p.result_addr = r.block_addr;
      end else begin
        // Take from the class before offering the old block
        if (fill_cnt[fit] > 0) begin
          fill_cnt[fit]--;
          cached_total  -= stk_size[fit][fill_cnt[fit]];
          p.action      = ACT_CACHED;
          p.result_addr = stk_addr[fit][fill_cnt[fit]];
        end else begin
          p.action       = ACT_MALLOC;
          p.backing_size = SIZE_W'(cls_bytes(fit));
        end
        if (r.block_addr != 0) begin
          p.copy_bytes = (r.old_size < r.new_size) ? r.old_size : r.new_size;
          p.old_fate   = offer_old(r.block_addr, r.block_usable);
        end
      end
    end
    return p;
  endfunction

  function automatic void cmp_field(string name, logic [63:0] e, logic [63:0] g);
    if (g !== e) begin
      $error("%s: expected %0h, got %0h", name, e, g);
      err_count++;
    end
  endfunction

  // Check results, track budget writes and predict each accepted request
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_rsp = 1'b1;
        if (pending_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          err_count++;
        end else begin
          e = pending_rsp_q.pop_front();
          cmp_field("action", e.action, out_rsp_o.action);
          cmp_field("result_addr", e.result_addr, out_rsp_o.result_addr);
          cmp_field("backing_size", e.backing_size, out_rsp_o.backing_size);
          cmp_field("copy_bytes", e.copy_bytes, out_rsp_o.copy_bytes);
          cmp_field("old_fate", e.old_fate, out_rsp_o.old_fate);
          rsp_count++;
          if (e.action == ACT_CACHED) hit_count++;
          if (e.action == ACT_KEEP) keep_count++;
          if (e.old_fate == FATE_KEPT) stash_count++;
        end
      end
      if (cfg_we_i) budget_shadow = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        pending_rsp_q.push_back(predict_call(in_req_i));
        req_count++;
      end
    end
  end

  // Stall the result channel: a fresh random wait after each result when idling is on
  always @(negedge clk_i) begin
    if (got_rsp) begin
      stall_left = idle_on ? $urandom_range(0, 15) : 0;
      got_rsp    = 1'b0;
    end
    out_stall_i = hold_rx || (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic logic [SIZE_W-1:0] rand40();
    return {8'($urandom), $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Usable size that lands in class c
  function automatic logic [SIZE_W-1:0] usable_in(int c);
    longint unsigned lo, hi;
    lo = cls_bytes(c);
    hi = (c < NCLS - 1) ? cls_bytes(c + 1) - 1 : 2 * cls_bytes(NCLS-1);
    return SIZE_W'(lo + $urandom_range(0, int'(hi - lo)));
  endfunction

  // Request size that fits class c
  function automatic logic [SIZE_W-1:0] size_for(int c);
    longint unsigned lo;
    lo = (c == 0) ? SMALL_LIMIT + 1 : cls_bytes(c - 1) + 1;
    return SIZE_W'($urandom_range(int'(lo), int'(cls_bytes(c))));
  endfunction

  function automatic req_t mk(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] u,
                              logic [SIZE_W-1:0] o, logic [SIZE_W-1:0] n);
    req_t r;
    r.block_addr   = a;
    r.block_usable = u;
    r.old_size     = o;
    r.new_size     = n;
    return r;
  endfunction

  // Mostly well-formed calls on a few busy classes, the rest noise
  function automatic req_t rand_req();
    req_t r;
    int   k, c;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] o;
    k = $urandom_range(0, 99);
    c = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, NCLS - 1);
    a = ($urandom_range(0, 19) == 0) ? '0 : rand48();
    o = $urandom_range(0, 1) ? rand40() : SIZE_W'($urandom_range(0, 4194304));
    if (k < 35) begin
      r = mk(a, usable_in(c), o, '0);
    end else if (k < 60) begin
      r = mk('0, rand40(), o, size_for(c));
    end else if (k < 80) begin
      r = mk(a, usable_in($urandom_range(0, NCLS - 1)), o, size_for(c));
    end else if (k < 88) begin
      r = mk(a, usable_in(c), o, size_for(c));
    end else begin
      r = mk(rand48(), rand40(), rand40(), rand40());
      if ($urandom_range(0, 3) == 0) r.new_size = SIZE_W'($urandom_range(0, 32768));
      if ($urandom_range(0, 3) == 0) r.new_size = '0;
    end
    return r;
  endfunction

  // Offer one request after a random gap when idling is on; return at the falling edge after acceptance
  task automatic send_req(input req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every outstanding result, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] v);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Field extremes, every action and each corner of the call flow
  task automatic test_directed();
    send_req(mk('0, '0, '0, '0));                              // release of no block
    send_req(mk('1, 40960, 0, 0));                             // keep in class 0
    send_req(mk(48'h1000, 40959, 0, 0));                       // too small to keep
    send_req(mk(48'h2000, 4194304, 0, 0));                     // top of largest class
    send_req(mk(48'h3000, 4194305, 0, 0));                     // just too big to keep
    send_req(mk(48'h4000, '1, '1, '0));
    send_req(mk('0, '0, '0, 32768));                           // small, no block
    send_req(mk('0, '0, '0, 32769));                           // hit in class 0
    send_req(mk('0, '0, '0, 2097152));                         // hit in largest class
    send_req(mk('0, '0, '0, 2097153));                         // above classes, no block
    send_req(mk(48'h5000, '1, '1, '1));                        // forwarded realloc
    send_req(mk(48'h6000, 50000, 1000, 1));
    send_req(mk(48'h7000, 50000, 30000, 45000));               // same block kept
    send_req(mk(48'h8000, 40960, 70000, 100000));              // move, class empty
    send_req(mk(48'h9000, 100000, 0, 0));
    send_req(mk(48'hA000, 60000, 200000, 90000));              // move, class hit
    send_req(mk(48'hB000, 100, 5000, 40000));                  // move, old freed
    send_req(mk(48'hC000, '1, '1, 2097152));
    send_req(mk(48'hD000, 2097152, 0, 1048577));
    send_req(mk('0, 4194304, '1, 40'h80_0000_0000));
    wait_idle();
  endtask

  // Overfill one class past its depth, then drain it past empty
  task automatic test_class_fill();
    repeat (DEPTH + 2) send_req(mk(rand48() | 48'h1, usable_in(2), rand40(), '0));
    repeat (DEPTH + 2) send_req(mk('0, '0, rand40(), size_for(2)));
    wait_idle();
  endtask

  // Zero budget, full budget, and a budget lowered under the cached total
  task automatic test_budget();
    write_budget('0);
    repeat (3) send_req(mk(rand48() | 48'h1, usable_in(0), '0, '0));
    write_budget(BUDGET_W'(BUDGET_MAX));
    repeat (3) send_req(mk(rand48() | 48'h1, 3000000, '0, '0));
    write_budget(BUDGET_W'(1000000));
    repeat (3) send_req(mk(rand48() | 48'h1, usable_in(0), '0, '0));
    repeat (3) send_req(mk('0, '0, '0, size_for(NCLS - 1)));
    repeat (3) send_req(mk(rand48() | 48'h1, usable_in(1), '0, '0));
    write_budget(BUDGET_W'(BUDGET_MAX));
    repeat (3) send_req(mk(rand48() | 48'h1, usable_in(3), '0, '0));
    wait_idle();
  endtask

  // Random calls in segments, some segments without any idling
  task automatic test_random();
    for (int s = 0; s < 15; s++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (50) send_req(rand_req());
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  // Hold the result channel for a long stretch while requests keep coming
  task automatic test_backpressure();
    idle_on = 1'b0;
    fork
      begin
        @(posedge clk_i);
        hold_rx = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        repeat (40) send_req(rand_req());
      end
    join
    idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    idle_on     = 1'b1;
    hold_rx     = 1'b0;
    got_rsp     = 1'b0;
    stall_left  = 0;
    err_count   = 0;
    req_count   = 0;
    rsp_count   = 0;
    hit_count   = 0;
    keep_count  = 0;
    stash_count = 0;
    for (int i = 0; i < NCLS; i++) fill_cnt[i] = 0;
    cached_total  = 0;
    budget_shadow = BUDGET_MAX;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_budget(BUDGET_W'(BUDGET_MAX));
    test_directed();
    test_class_fill();
    test_budget();
    test_backpressure();
    test_random();
    write_budget(BUDGET_W'(BUDGET_MAX));
    wait_idle();
    repeat (20) @(negedge clk_i);

    $display("summary: %0d requests, %0d results checked, %0d errors", req_count, rsp_count,
             err_count);
    $display("summary: %0d cache hits, %0d blocks kept in place, %0d blocks stashed",
             hit_count, keep_count, stash_count);
    if (err_count == 0 && pending_rsp_q.size() == 0) begin
      $display("tb_size_class_block_cache: clean");
    end else begin
      if (pending_rsp_q.size() != 0) $error("%0d results never arrived", pending_rsp_q.size());
      $display("tb_size_class_block_cache: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("tb_size_class_block_cache: errors");
    $finish;
  end

endmodule
